[rtl/core/lfs_pkg.sv]
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants for the line-follow steering core: beat
// payloads, configuration register set, register indexes and mode codes.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int SENSOR_BITS = 10;
  localparam int TIMER_BITS  = 16;
  localparam int TICK_BITS   = 8;
  localparam int DUTY_BITS   = 8;
  localparam int LEVEL_BITS  = 3;
  localparam int CMP_BITS    = 13;
  localparam int CUT_BITS    = 11;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [LEVEL_BITS-1:0] TOP_LEVEL = 3'd5;

  typedef enum logic [3:0] {
    MODE_STRAIGHT = 4'd0,
    MODE_STOP     = 4'd1,
    MODE_RIGHT1   = 4'd2,
    MODE_RIGHT2   = 4'd3,
    MODE_RIGHT3   = 4'd4,
    MODE_RIGHT4   = 4'd5,
    MODE_RIGHT5   = 4'd6,
    MODE_LEFT1    = 4'd7,
    MODE_LEFT2    = 4'd8,
    MODE_LEFT3    = 4'd9,
    MODE_LEFT4    = 4'd10,
    MODE_LEFT5    = 4'd11,
    MODE_SHORTCUT = 4'd12
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BASE_LEVEL    = 3'd0,
    REG_LEVEL_STEP    = 3'd1,
    REG_CROSS_LEVEL   = 3'd2,
    REG_SHORTCUT_TIME = 3'd3,
    REG_CRUISE_DUTY   = 3'd4,
    REG_DUTY_STEP     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [9:0]  ladder_base_level;
    logic [7:0]  ladder_level_step;
    logic [9:0]  cross_level;
    logic [15:0] shortcut_time;
    logic [7:0]  cruise_duty;
    logic [7:0]  duty_step;
  } cfg_t;

  typedef struct packed {
    logic [SENSOR_BITS-1:0] timer_sensor_low;
    logic [SENSOR_BITS-1:0] right_turn_sensor;
    logic [SENSOR_BITS-1:0] left_turn_sensor;
    logic [SENSOR_BITS-1:0] timer_sensor_high;
    logic                   start_jack;
    logic                   end_switch;
    logic [TICK_BITS-1:0]   timer_ticks;
  } in_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] left_duty;
    logic [DUTY_BITS-1:0] right_duty;
    logic [3:0]           mode;
    logic                 motors_enabled;
  } out_t;

endpackage

[rtl/core/line_follow_steering_fsm_core.sv]
// ----------------------------------------------------------------------------
// line_follow_steering_fsm_core
// Line-follow steering controller: one sensor frame in, one duty/mode
// result out.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item) carries one sensor frame per
// beat; output channel (out_valid / out_stall / out_item) carries the motor
// duties, the new steering mode and the motor enable for that frame.
// Configuration writes use cfg_valid / cfg_ready with a register index and
// data; cfg_ready is always high and unknown indexes are dropped. Write
// only while no frame is in flight.
// Path: a frame accepted into the input register is processed by the
// steering logic and loaded into the result register, where out_valid
// rises; a stalled result holds it in the input register.
// Throughput: one frame per cycle while the receiver does not stall, set by
// the mode update that closes the state loop between consecutive frames.
// Reset (rst, synchronous): straight mode, timer cleared and stopped,
// motors off, registers back to their defaults, both channels empty.
// When the receiver stalls, the result register holds; a frame can still be
// taken into an empty input register, and in_stall rises while it is full.
// ----------------------------------------------------------------------------
module line_follow_steering_fsm_core #(
  parameter int TIMER_BITS = lfs_pkg::TIMER_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lfs_pkg::in_t                       in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lfs_pkg::out_t                      out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lfs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lfs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic          in_busy, advance, in_take;
  lfs_pkg::in_t  in_reg;
  lfs_pkg::out_t result;
  lfs_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;
  assign advance   = in_busy && !(out_valid && out_stall);
  assign in_stall  = in_busy && out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;

  lfs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lfs_steer #(
    .TIMER_BITS (TIMER_BITS)
  ) u_steer (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_reg),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_busy   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) in_busy <= 1'b1;
      else if (advance) in_busy <= 1'b0;
      if (advance) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_reg <= in_item;
    if (advance) out_item <= result;
  end

`ifndef SYNTHESIS
  a_adv_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed beat did not reach the result register");

  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && in_busy && (out_item.mode == 4'(lfs_pkg::MODE_STOP))
    |=> (out_item.mode == 4'(lfs_pkg::MODE_STOP)) && (out_item.left_duty == '0)
        && (out_item.right_duty == '0))
    else $error("stop mode left or drove the motors");

  a_shortcut_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && in_busy && (out_item.mode == 4'(lfs_pkg::MODE_SHORTCUT))
    |=> ((out_item.mode == 4'(lfs_pkg::MODE_SHORTCUT))
         || (out_item.mode == 4'(lfs_pkg::MODE_STOP)))
        && (out_item.left_duty == '0) && (out_item.right_duty == '0))
    else $error("shortcut stop left or drove the motors");

  a_enable_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && in_busy && out_item.motors_enabled |=> out_item.motors_enabled)
    else $error("motor enable dropped");
`endif

endmodule

[rtl/core/lfs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lfs_cfg_regs
// Configuration register set; one write beat per cycle, unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module lfs_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [lfs_pkg::CFG_IDX_BITS-1:0]   wr_index,
  input  logic [lfs_pkg::CFG_DATA_BITS-1:0]  wr_data,
  output lfs_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ladder_base_level <= 10'd200;
      cfg.ladder_level_step <= 8'd100;
      cfg.cross_level       <= 10'd800;
      cfg.shortcut_time     <= 16'd37500;
      cfg.cruise_duty       <= 8'd150;
      cfg.duty_step         <= 8'd30;
    end else if (wr_en) begin
      unique case (lfs_pkg::cfg_idx_t'(wr_index))
        lfs_pkg::REG_BASE_LEVEL:    cfg.ladder_base_level <= wr_data[9:0];
        lfs_pkg::REG_LEVEL_STEP:    cfg.ladder_level_step <= wr_data[7:0];
        lfs_pkg::REG_CROSS_LEVEL:   cfg.cross_level       <= wr_data[9:0];
        lfs_pkg::REG_SHORTCUT_TIME: cfg.shortcut_time     <= wr_data[15:0];
        lfs_pkg::REG_CRUISE_DUTY:   cfg.cruise_duty       <= wr_data[7:0];
        lfs_pkg::REG_DUTY_STEP:     cfg.duty_step         <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/lfs_steer.sv]
// ----------------------------------------------------------------------------
// lfs_steer
// Steering state machine: shortcut timer, motor enable and mode update,
// with the motor duties decoded from the mode in force for the frame.
// ----------------------------------------------------------------------------
module lfs_steer #(
  parameter int TIMER_BITS = lfs_pkg::TIMER_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  lfs_pkg::in_t  item,
  input  lfs_pkg::cfg_t cfg,
  output lfs_pkg::out_t result
);

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam int CB = lfs_pkg::CMP_BITS;
  localparam int LB = lfs_pkg::LEVEL_BITS;
  localparam int KB = lfs_pkg::CUT_BITS;

  lfs_pkg::mode_t          mode, mode_next, mode_eff;
  logic [TIMER_BITS-1:0]   timer, timer_next, timer_adv;
  logic                    timer_started, timer_started_next;
  logic                    motors_on, motors_on_next;
  logic                    start_hit, in_right, in_left, cross_hit;
  logic [CB-1:0]           s_low, s_high, s_right, s_left, s_side, base_c, up, down;
  logic [LB-1:0]           lvl, new_lvl;
  logic [KB-1:0]           cut;
  logic [lfs_pkg::DUTY_BITS-1:0] inner, left_duty, right_duty;

  always_comb begin
    mode_eff  = item.end_switch ? mode : lfs_pkg::MODE_STOP;
    timer_adv = timer_started ? timer + TIMER_BITS'(item.timer_ticks) : timer;
    s_low     = CB'(item.timer_sensor_low);
    s_high    = CB'(item.timer_sensor_high);
    s_right   = CB'(item.right_turn_sensor);
    s_left    = CB'(item.left_turn_sensor);
    base_c    = CB'(cfg.ladder_base_level);
    start_hit = (s_low < base_c) && (s_high > base_c);
    timer_next         = start_hit ? '0 : timer_adv;
    timer_started_next = timer_started | start_hit;
    motors_on_next     = motors_on | item.start_jack;
    cross_hit = (s_left > CB'(cfg.cross_level)) && (s_right > CB'(cfg.cross_level));
    in_right  = (mode_eff >= lfs_pkg::MODE_RIGHT1) && (mode_eff <= lfs_pkg::MODE_RIGHT5);
    in_left   = (mode_eff >= lfs_pkg::MODE_LEFT1) && (mode_eff <= lfs_pkg::MODE_LEFT5);
    lvl = in_right ? LB'(4'(mode_eff) - 4'(lfs_pkg::MODE_RIGHT1)) + LB'(1)
                   : LB'(4'(mode_eff) - 4'(lfs_pkg::MODE_LEFT1)) + LB'(1);
    s_side = in_right ? s_right : s_left;
    up   = base_c + CB'(lvl) * CB'(cfg.ladder_level_step);
    down = base_c + CB'(lvl - LB'(1)) * CB'(cfg.ladder_level_step);
    cut  = KB'(lvl) * KB'(cfg.duty_step);
    inner = (cut >= KB'(cfg.cruise_duty)) ? '0
          : lfs_pkg::DUTY_BITS'(KB'(cfg.cruise_duty) - cut);
    priority if ((lvl < lfs_pkg::TOP_LEVEL) && (s_side > up)) new_lvl = lvl + LB'(1);
    else if (s_side < down) new_lvl = lvl - LB'(1);
    else new_lvl = lvl;
  end

  // next state
  always_comb begin
    priority if (mode_eff == lfs_pkg::MODE_STRAIGHT) begin
      mode_next = (CW'(timer_next) > CW'(cfg.shortcut_time)) ? lfs_pkg::MODE_SHORTCUT
                                                              : lfs_pkg::MODE_STRAIGHT;
      priority if (cross_hit) mode_next = lfs_pkg::MODE_STOP;
      else if (s_right > base_c) mode_next = lfs_pkg::MODE_RIGHT1;
      else if (s_left > base_c) mode_next = lfs_pkg::MODE_LEFT1;
      else mode_next = mode_next;
    end else if (in_right || in_left) begin
      if (new_lvl == '0) begin
        mode_next = lfs_pkg::MODE_STRAIGHT;
      end else begin
        mode_next = lfs_pkg::mode_t'(4'(new_lvl) - 4'd1 +
                    (in_right ? 4'(lfs_pkg::MODE_RIGHT1) : 4'(lfs_pkg::MODE_LEFT1)));
      end
    end else if (mode_eff == lfs_pkg::MODE_SHORTCUT) begin
      mode_next = lfs_pkg::MODE_SHORTCUT;
    end else begin
      mode_next = lfs_pkg::MODE_STOP;
    end
  end

  // outputs
  always_comb begin
    priority if (mode_eff == lfs_pkg::MODE_STRAIGHT) begin
      left_duty  = cfg.cruise_duty;
      right_duty = cfg.cruise_duty;
    end else if (in_right) begin
      left_duty  = cfg.cruise_duty;
      right_duty = inner;
    end else if (in_left) begin
      left_duty  = inner;
      right_duty = cfg.cruise_duty;
    end else begin
      left_duty  = '0;
      right_duty = '0;
    end
    result.left_duty      = left_duty;
    result.right_duty     = right_duty;
    result.mode           = 4'(mode_next);
    result.motors_enabled = motors_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= lfs_pkg::MODE_STRAIGHT;
      timer         <= '0;
      timer_started <= 1'b0;
      motors_on     <= 1'b0;
    end else if (advance) begin
      mode          <= mode_next;
      timer         <= timer_next;
      timer_started <= timer_started_next;
      motors_on     <= motors_on_next;
    end
  end

endmodule

[test/line_follow_steering_fsm_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follow_steering_fsm_core_tb
// Self-checking bench for the line-follow steering core. A short table of
// sensor frames walks the turn ladders, hysteresis and timer start, then
// phases of random frames run under several register settings and
// handshake pressures. Every result beat is checked field by field against
// a steering predictor kept in step with the accepted frames. The stop and
// shortcut modes never return to driving, so frames that would reach them
// are redrawn until the final phase, where they are let through.
// ----------------------------------------------------------------------------
module line_follow_steering_fsm_core_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [lfs_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [lfs_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] timer;
    logic        started;
    logic        motors;
  } steer_state_t;

  typedef struct {
    lfs_pkg::in_t  frame;
    bit            pinned;
    lfs_pkg::out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  lfs_pkg::in_t  in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lfs_pkg::out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lfs_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [lfs_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  logic [9:0]  cfg_base   = 10'd200;
  logic [7:0]  cfg_step   = 8'd100;
  logic [9:0]  cfg_cross  = 10'd800;
  logic [15:0] cfg_short  = 16'd37500;
  logic [7:0]  cfg_cruise = 8'd150;
  logic [7:0]  cfg_dstep  = 8'd30;

  steer_state_t  pred = '0;
  lfs_pkg::out_t expected[$];
  dir_row_t      plan[$];

  int  in_idle_pct   = 0;
  int  out_stall_pct = 0;
  bit  stop_allowed  = 1'b0;
  int  end_low_pct   = 0;
  int  mismatches    = 0;
  int  quiet         = 0;

  line_follow_steering_fsm_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] inner_duty(input int unsigned lvl);
    int unsigned cut, cr;
    cut = lvl * cfg_dstep;
    cr  = cfg_cruise;
    if (cut >= cr) return '0;
    return 8'(cr - cut);
  endfunction

  function automatic int unsigned ladder_next(input int unsigned lvl, input logic [9:0] s);
    int unsigned b, st, up, dn;
    b  = cfg_base;
    st = cfg_step;
    up = b + lvl * st;
    dn = b + (lvl - 1) * st;
    if (lvl < lfs_pkg::TOP_LEVEL && s > up) return lvl + 1;
    if (s < dn) return lvl - 1;
    return lvl;
  endfunction

  function automatic steer_state_t steer_next(input steer_state_t s, input lfs_pkg::in_t f,
                                              output lfs_pkg::out_t r);
    steer_state_t n;
    logic [3:0]   m;
    logic [7:0]   ld, rd;
    int unsigned  lvl;
    n = s;
    if (f.start_jack) n.motors = 1'b1;
    if (!f.end_switch) n.mode = lfs_pkg::MODE_STOP;
    if (n.started) n.timer = n.timer + f.timer_ticks;
    if (f.timer_sensor_low < cfg_base && f.timer_sensor_high > cfg_base) begin
      n.started = 1'b1;
      n.timer   = '0;
    end
    m = n.mode;
    if (m == lfs_pkg::MODE_STRAIGHT) begin
      ld = cfg_cruise;
      rd = cfg_cruise;
      if (n.timer > cfg_short) m = lfs_pkg::MODE_SHORTCUT;
      if (f.left_turn_sensor > cfg_cross && f.right_turn_sensor > cfg_cross) begin
        m = lfs_pkg::MODE_STOP;
      end else begin
        if (f.left_turn_sensor > cfg_base) m = lfs_pkg::MODE_LEFT1;
        if (f.right_turn_sensor > cfg_base) m = lfs_pkg::MODE_RIGHT1;
      end
    end else if (m >= lfs_pkg::MODE_RIGHT1 && m <= lfs_pkg::MODE_RIGHT5) begin
      lvl = m - lfs_pkg::MODE_RIGHT1 + 1;
      ld  = cfg_cruise;
      rd  = inner_duty(lvl);
      lvl = ladder_next(lvl, f.right_turn_sensor);
      if (lvl == 0) m = lfs_pkg::MODE_STRAIGHT;
      else m = 4'(lfs_pkg::MODE_RIGHT1 + lvl - 1);
    end else if (m >= lfs_pkg::MODE_LEFT1 && m <= lfs_pkg::MODE_LEFT5) begin
      lvl = m - lfs_pkg::MODE_LEFT1 + 1;
      ld  = inner_duty(lvl);
      rd  = cfg_cruise;
      lvl = ladder_next(lvl, f.left_turn_sensor);
      if (lvl == 0) m = lfs_pkg::MODE_STRAIGHT;
      else m = 4'(lfs_pkg::MODE_LEFT1 + lvl - 1);
    end else begin
      ld = '0;
      rd = '0;
      if (m != lfs_pkg::MODE_SHORTCUT) m = lfs_pkg::MODE_STOP;
    end
    n.mode = m;
    r.left_duty      = ld;
    r.right_duty     = rd;
    r.mode           = n.mode;
    r.motors_enabled = n.motors;
    return n;
  endfunction

  function automatic bit halted(input logic [3:0] m);
    return m == lfs_pkg::MODE_STOP || m == lfs_pkg::MODE_SHORTCUT;
  endfunction

  // bias towards the thresholds of the current ladder level
  function automatic logic [9:0] pick_sensor(input int unsigned lvl);
    int t, k, b, st;
    b  = cfg_base;
    st = cfg_step;
    k  = lvl;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t = $urandom_range(0, 1023);
      4, 5, 6: begin
        if (lvl > 0 && $urandom_range(0, 1)) k = lvl - 1;
        t = b + k * st + $urandom_range(0, 4) - 2;
      end
      7, 8: t = $urandom_range(0, b);
      default: t = 1023;
    endcase
    if (t < 0) t = 0;
    if (t > 1023) t = 1023;
    return t[9:0];
  endfunction

  function automatic lfs_pkg::in_t draw_frame();
    lfs_pkg::in_t  f;
    lfs_pkg::out_t o;
    steer_state_t  nx;
    int unsigned   rl, ll;
    rl = 0;
    ll = 0;
    if (pred.mode >= lfs_pkg::MODE_RIGHT1 && pred.mode <= lfs_pkg::MODE_RIGHT5)
      rl = pred.mode - lfs_pkg::MODE_RIGHT1 + 1;
    if (pred.mode >= lfs_pkg::MODE_LEFT1 && pred.mode <= lfs_pkg::MODE_LEFT5)
      ll = pred.mode - lfs_pkg::MODE_LEFT1 + 1;
    for (int k = 0; k < 16; k++) begin
      f.timer_sensor_low  = pick_sensor(0);
      f.right_turn_sensor = pick_sensor(rl);
      f.left_turn_sensor  = pick_sensor(ll);
      f.timer_sensor_high = pick_sensor(0);
      f.start_jack        = ($urandom_range(0, 3) == 0);
      f.end_switch        = !($urandom_range(0, 99) < end_low_pct);
      f.timer_ticks       = 8'($urandom_range(0, 255));
      nx = steer_next(pred, f, o);
      if (stop_allowed || !halted(nx.mode)) return f;
    end
    // rescue: restart the timer, keep both sides dark
    f.end_switch        = 1'b1;
    f.right_turn_sensor = '0;
    f.left_turn_sensor  = '0;
    f.timer_sensor_low  = '0;
    f.timer_sensor_high = '1;
    f.timer_ticks       = '0;
    nx = steer_next(pred, f, o);
    if (!halted(nx.mode)) return f;
    f.right_turn_sensor = '1;
    return f;
  endfunction

  task automatic send_frame(input lfs_pkg::in_t f, input bit pinned, input lfs_pkg::out_t want);
    lfs_pkg::out_t o;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = steer_next(pred, f, o);
    expected.push_back(pinned ? want : o);
  endtask

  task automatic run_random(input int n);
    lfs_pkg::in_t f;
    repeat (n) begin
      f = draw_frame();
      send_frame(f, 1'b0, '0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lfs_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [lfs_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lfs_pkg::REG_BASE_LEVEL:    cfg_base   = data[9:0];
      lfs_pkg::REG_LEVEL_STEP:    cfg_step   = data[7:0];
      lfs_pkg::REG_CROSS_LEVEL:   cfg_cross  = data[9:0];
      lfs_pkg::REG_SHORTCUT_TIME: cfg_short  = data;
      lfs_pkg::REG_CRUISE_DUTY:   cfg_cruise = data[7:0];
      lfs_pkg::REG_DUTY_STEP:     cfg_dstep  = data[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [9:0] b, input logic [7:0] st,
                               input logic [9:0] cr, input logic [15:0] sh,
                               input logic [7:0] cd, input logic [7:0] ds);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(lfs_pkg::REG_BASE_LEVEL, {junk[15:10], b});
    junk = 16'($urandom);
    write_reg(lfs_pkg::REG_LEVEL_STEP, {junk[15:8], st});
    junk = 16'($urandom);
    write_reg(lfs_pkg::REG_CROSS_LEVEL, {junk[15:10], cr});
    write_reg(lfs_pkg::REG_SHORTCUT_TIME, sh);
    junk = 16'($urandom);
    write_reg(lfs_pkg::REG_CRUISE_DUTY, {junk[15:8], cd});
    junk = 16'($urandom);
    write_reg(lfs_pkg::REG_DUTY_STEP, {junk[15:8], ds});
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [9:0] lo, input logic [9:0] rt, input logic [9:0] lf,
                         input logic [9:0] hi, input logic jack, input logic [7:0] ticks);
    dir_row_t r;
    r.frame.timer_sensor_low  = lo;
    r.frame.right_turn_sensor = rt;
    r.frame.left_turn_sensor  = lf;
    r.frame.timer_sensor_high = hi;
    r.frame.start_jack        = jack;
    r.frame.end_switch        = 1'b1;
    r.frame.timer_ticks       = ticks;
    r.pinned = 1'b0;
    r.want   = '0;
    plan.push_back(r);
  endtask

  task automatic pin_result(input logic [7:0] ld, input logic [7:0] rd,
                            input lfs_pkg::mode_t md, input logic en);
    dir_row_t r;
    r = plan.pop_back();
    r.pinned              = 1'b1;
    r.want.left_duty      = ld;
    r.want.right_duty     = rd;
    r.want.mode           = md;
    r.want.motors_enabled = en;
    plan.push_back(r);
  endtask

  task automatic note_fault(input string tag, input lfs_pkg::out_t want,
                            input lfs_pkg::out_t got);
    if (mismatches < 10)
      $display("%0t %s: want L%0d R%0d M%0d E%0d got L%0d R%0d M%0d E%0d", $realtime, tag,
               want.left_duty, want.right_duty, want.mode, want.motors_enabled,
               got.left_duty, got.right_duty, got.mode, got.motors_enabled);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    lfs_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected.size() == 0) begin
        note_fault("unexpected beat", '0, out_item);
      end else begin
        want = expected.pop_front();
        if (out_item.left_duty !== want.left_duty || out_item.right_duty !== want.right_duty ||
            out_item.mode !== want.mode ||
            out_item.motors_enabled !== want.motors_enabled)
          note_fault("mismatch", want, out_item);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("line_follow_steering_fsm_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned sh;
    add_row(10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 8'd0);
    pin_result(8'd150, 8'd150, lfs_pkg::MODE_STRAIGHT, 1'b0);
    add_row(10'd0, 10'd201, 10'd0, 10'd0, 1'b0, 8'd0);
    pin_result(8'd150, 8'd150, lfs_pkg::MODE_RIGHT1, 1'b0);
    add_row(10'd0, 10'd301, 10'd0, 10'd0, 1'b1, 8'd0);
    pin_result(8'd150, 8'd120, lfs_pkg::MODE_RIGHT2, 1'b1);
    add_row(10'd0, 10'd350, 10'd0, 10'd0, 1'b0, 8'd0);
    add_row(10'd0, 10'd400, 10'd0, 10'd0, 1'b0, 8'd0);
    add_row(10'd0, 10'd300, 10'd0, 10'd0, 1'b0, 8'd0);
    repeat (3) add_row(10'd0, 10'd1023, 10'd0, 10'd0, 1'b0, 8'd0);
    add_row(10'd0, 10'd1023, 10'd0, 10'd0, 1'b0, 8'd0);
    pin_result(8'd150, 8'd0, lfs_pkg::MODE_RIGHT5, 1'b1);
    repeat (5) add_row(10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 8'd0);
    add_row(10'd0, 10'd500, 10'd500, 10'd0, 1'b0, 8'd0);
    add_row(10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 8'd0);
    add_row(10'd0, 10'd0, 10'd201, 10'd0, 1'b0, 8'd0);
    add_row(10'd0, 10'd0, 10'd1023, 10'd0, 1'b0, 8'd0);
    repeat (2) add_row(10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 8'd0);
    add_row(10'd0, 10'd800, 10'd1023, 10'd0, 1'b0, 8'd0);
    add_row(10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 8'd0);
    add_row(10'd199, 10'd0, 10'd0, 10'd201, 1'b0, 8'd255);
    add_row(10'd200, 10'd0, 10'd0, 10'd1023, 1'b0, 8'd255);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_frame(plan[i].frame, plan[i].pinned, plan[i].want);
    run_random(250);

    // extremes: lowest ladder, widest cross level, shortcut out of reach
    settle();
    in_idle_pct = 46;
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    load_settings(10'd0, 8'd1, 10'd1023, 16'hFFFF, 8'd255, 8'd255);
    run_random(250);

    settle();
    in_idle_pct   = 0;
    out_stall_pct = 46;
    load_settings(10'd1023, 8'd255, 10'd0, 16'hFFFF, 8'd0, 8'd0);
    run_random(100);

    settle();
    load_settings(10'($urandom_range(100, 400)), 8'($urandom_range(20, 150)),
                  10'($urandom_range(700, 1023)), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 80)));
    run_random(150);

    settle();
    in_idle_pct   = 7;
    out_stall_pct = 7;
    load_settings(10'($urandom_range(100, 400)), 8'($urandom_range(20, 150)),
                  10'($urandom_range(700, 1023)), 16'($urandom_range(500, 5000)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 80)));
    run_random(300);

    settle();
    in_idle_pct   = 46;
    out_stall_pct = 0;
    load_settings(10'($urandom_range(100, 400)), 8'($urandom_range(1, 255)),
                  10'($urandom_range(600, 1023)), 16'($urandom_range(200, 3000)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random(150);

    // let stop and shortcut through; neither may return to driving from then on
    settle();
    in_idle_pct   = 7;
    out_stall_pct = 7;
    stop_allowed  = 1'b1;
    end_low_pct   = 10;
    sh = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(100, 4000);
    load_settings(10'($urandom_range(150, 300)), 8'($urandom_range(50, 150)),
                  10'($urandom_range(600, 900)), 16'(sh),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 60)));
    run_random(200);

    settle();
    if (mismatches == 0 && expected.size() == 0) begin
      $display("line_follow_steering_fsm_core_tb: PASS");
    end else begin
      $display("line_follow_steering_fsm_core_tb: FAIL");
    end
    $finish;
  end

endmodule
